### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertions on clk with rst_n as the disable condition
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif

`endif

### hdl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types, codes and helpers of the bmp pixel unpacker
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

    localparam logic [12:0] MAX_WIDTH       = 13'd4096;
    localparam logic [12:0] MAX_HEIGHT      = 13'd4096;
    localparam int          PALETTE_ENTRIES = 256;
    localparam int          COLOR_W         = 24;

    localparam logic [1:0] CMD_START     = 2'd0;
    localparam logic [1:0] CMD_PAL_WRITE = 2'd1;
    localparam logic [1:0] CMD_DATA      = 2'd2;
    localparam logic [1:0] CMD_RESERVED  = 2'd3;

    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_4BPP  = 3'd1;
    localparam logic [2:0] FMT_8BPP  = 3'd2;
    localparam logic [2:0] FMT_24BPP = 3'd3;
    localparam logic [2:0] FMT_32BPP = 3'd4;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        OP_START,
        OP_PAL_WRITE,
        OP_DATA
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] pal_index;
        logic [7:0] pal_red;
        logic [7:0] pal_green;
        logic [7:0] pal_blue;
        logic [7:0] data;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } queue_head_t;

    typedef struct packed {
        logic [2:0]  pixel_format;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [1:0]  row_pad_bytes;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
        logic        last_of_byte;
        logic        image_done;
    } pixel_t;

    function automatic logic [12:0] clamp_dim(input logic [12:0] v, input logic [12:0] maxv);
        logic [12:0] r;
        r = v;
        if (v == 13'd0)
        begin
            r = 13'd1;
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/bpa_front.sv
// ----------------------------------------------------------------------------
// bpa_front
// accepts requests, classifies the command and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bpa_front
    import bpa_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  palette_index,
    input  wire logic [7:0]  palette_red,
    input  wire logic [7:0]  palette_green,
    input  wire logic [7:0]  palette_blue,
    input  wire logic [7:0]  data_byte,
    output queue_head_t      head,
    input  wire logic        pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    req_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          keep;
    logic          push;
    req_t          req;

    // classify
    always_comb
    begin
        req.op        = OP_DATA;
        req.pal_index = palette_index;
        req.pal_red   = palette_red;
        req.pal_green = palette_green;
        req.pal_blue  = palette_blue;
        req.data      = data_byte;
        keep          = 1'b1;
        unique case (command)
            CMD_START:     req.op = OP_START;
            CMD_PAL_WRITE: req.op = OP_PAL_WRITE;
            CMD_DATA:      req.op = OP_DATA;
            default:       keep   = 1'b0;
        endcase
    end

    assign in_stall = (count_reg == CW'(DEPTH));
    assign push     = in_valid && !in_stall && keep;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= req;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.req   = mem_reg[rd_ptr_reg];

    `ASSERT_CLK(a_count_bound, count_reg <= CW'(DEPTH), "queue count above depth")
    `ASSERT_NEVER(a_pop_empty, pop && count_reg == '0, "pop from empty queue")
    `ASSERT_CLK(a_empty_ptrs, count_reg == '0 |-> rd_ptr_reg == wr_ptr_reg, "empty queue ptr skew")

endmodule

`default_nettype wire

### hdl/bpa_back.sv
// ----------------------------------------------------------------------------
// bpa_back
// sequences queued requests into pixels, palette lookup and output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bpa_back
    import bpa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire queue_head_t head,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output pixel_t           pixel
);

    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    typedef struct packed {
        logic                use_pal;
        logic                pal_hit;
        logic [COLOR_W-1:0]  rgb;
        logic [7:0]          alpha;
        logic [11:0]         column;
        logic [11:0]         row;
        logic                last;
        logic                done;
    } stage_t;

    logic [PALETTE_ENTRIES-1:0] pal_valid_reg;
    logic [PALETTE_ENTRIES-1:0] pal_valid_next;
    logic [23:0]                gather_reg;
    logic [23:0]                gather_next;
    logic [1:0]                 phase_reg;
    logic [1:0]                 phase_next;
    logic [11:0]                col_reg;
    logic [11:0]                col_next;
    logic [11:0]                row_reg;
    logic [11:0]                row_next;
    logic [1:0]                 pad_reg;
    logic [1:0]                 pad_next;
    logic                       finished_reg;
    logic                       finished_next;
    logic                       in_byte_reg;
    logic                       in_byte_next;
    logic [2:0]                 shift_reg;
    logic [2:0]                 shift_next;
    logic                       p1_valid_reg;
    stage_t                     p1_reg;
    stage_t                     p1_next;
    logic                       out_valid_reg;
    pixel_t                     out_reg;

    logic [12:0]        w;
    logic [12:0]        h;
    logic               out_adv;
    logic               p1_adv;
    logic               go;
    logic [3:0]         bits;
    logic [2:0]         shift_start;
    logic [7:0]         mask;
    logic [2:0]         cur_shift;
    logic [7:0]         pix_index;
    logic               row_end;
    logic               last_row;
    logic [11:0]        out_row;
    logic [23:0]        gather_upd;
    logic               complete;
    logic               emit;
    logic               ram_we;
    logic               ram_re;
    logic [COLOR_W-1:0] rd_data;
    logic [COLOR_W-1:0] p1_rgb;

    assign w        = clamp_dim(cfg.image_width, MAX_WIDTH);
    assign h        = clamp_dim(cfg.image_height, MAX_HEIGHT);
    assign out_adv  = !out_valid_reg || !out_stall;
    assign p1_adv   = p1_valid_reg && out_adv;
    assign go       = head.valid && (!p1_valid_reg || out_adv);
    assign row_end  = ({1'b0, col_reg} + 13'd1) >= w;
    assign last_row = ({1'b0, row_reg} + 13'd1) >= h;
    assign out_row  = 12'(h - 13'd1 - {1'b0, row_reg});

    always_comb
    begin
        unique case (cfg.pixel_format)
            FMT_1BPP:
            begin
                bits = 4'd1;
                mask = 8'h01;
            end
            FMT_4BPP:
            begin
                bits = 4'd4;
                mask = 8'h0F;
            end
            default:
            begin
                bits = 4'd8;
                mask = 8'hFF;
            end
        endcase
        shift_start = 3'(4'd8 - bits);
        cur_shift   = in_byte_reg ? shift_reg : shift_start;
        pix_index   = (head.req.data >> cur_shift) & mask;
    end

    // true-color byte gather, B in the low byte
    always_comb
    begin
        case (phase_reg)
            2'd0:    gather_upd = {gather_reg[23:8], head.req.data};
            2'd1:    gather_upd = {gather_reg[23:16], head.req.data, gather_reg[7:0]};
            2'd2:    gather_upd = {head.req.data, gather_reg[15:0]};
            default: gather_upd = gather_reg;
        endcase
        complete = (cfg.pixel_format == FMT_24BPP) ? (phase_reg >= 2'd2) : (phase_reg == 2'd3);
    end

    // sequencer
    always_comb
    begin
        pal_valid_next = pal_valid_reg;
        gather_next    = gather_reg;
        phase_next     = phase_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        pad_next       = pad_reg;
        finished_next  = finished_reg;
        in_byte_next   = in_byte_reg;
        shift_next     = shift_reg;
        pop            = 1'b0;
        emit           = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        p1_next.use_pal = 1'b1;
        p1_next.pal_hit = pal_valid_reg[pix_index];
        p1_next.rgb     = {gather_upd[23:16], gather_upd[15:8], gather_upd[7:0]};
        p1_next.alpha   = ALPHA_OPAQUE;
        p1_next.column  = col_reg;
        p1_next.row     = out_row;
        p1_next.last    = 1'b1;
        p1_next.done    = row_end && last_row;
        if (go)
        begin
            unique case (head.req.op)
                OP_START:
                begin
                    gather_next   = '0;
                    phase_next    = '0;
                    col_next      = '0;
                    row_next      = '0;
                    pad_next      = '0;
                    finished_next = 1'b0;
                    in_byte_next  = 1'b0;
                    pop           = 1'b1;
                end
                OP_PAL_WRITE:
                begin
                    ram_we                             = 1'b1;
                    pal_valid_next[head.req.pal_index] = 1'b1;
                    pop                                = 1'b1;
                end
                OP_DATA:
                begin
                    if (!in_byte_reg && finished_reg)
                    begin
                        pop = 1'b1;
                    end
                    else if (!in_byte_reg && ({1'b0, row_reg} >= h))
                    begin
                        finished_next = 1'b1;
                        pop           = 1'b1;
                    end
                    else if (!in_byte_reg && pad_reg != 2'd0)
                    begin
                        pad_next = pad_reg - 2'd1;
                        pop      = 1'b1;
                    end
                    else if (cfg.pixel_format <= FMT_8BPP)
                    begin
                        emit         = 1'b1;
                        ram_re       = 1'b1;
                        p1_next.last = row_end || ({1'b0, cur_shift} < bits);
                        if (p1_next.last)
                        begin
                            pop          = 1'b1;
                            in_byte_next = 1'b0;
                        end
                        else
                        begin
                            in_byte_next = 1'b1;
                            shift_next   = 3'({1'b0, cur_shift} - bits);
                        end
                    end
                    else if (cfg.pixel_format == FMT_24BPP || cfg.pixel_format == FMT_32BPP)
                    begin
                        gather_next = gather_upd;
                        pop         = 1'b1;
                        if (complete)
                        begin
                            emit            = 1'b1;
                            phase_next      = '0;
                            p1_next.use_pal = 1'b0;
                            if (cfg.pixel_format == FMT_32BPP)
                            begin
                                p1_next.alpha = head.req.data;
                            end
                        end
                        else
                        begin
                            phase_next = phase_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
        // position update for an emitted pixel
        if (emit)
        begin
            if (row_end)
            begin
                col_next   = '0;
                pad_next   = cfg.row_pad_bytes;
                phase_next = '0;
                if (last_row)
                begin
                    finished_next = 1'b1;
                    row_next      = '0;
                end
                else
                begin
                    row_next = row_reg + 12'd1;
                end
            end
            else
            begin
                col_next = col_reg + 12'd1;
            end
        end
    end

    bpa_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head.req.pal_index[PAL_AW-1:0]),
        .wdata ({head.req.pal_red, head.req.pal_green, head.req.pal_blue}),
        .re    (ram_re),
        .raddr (pix_index[PAL_AW-1:0]),
        .rdata (rd_data)
    );

    assign p1_rgb = p1_reg.use_pal ? (p1_reg.pal_hit ? rd_data : '0) : p1_reg.rgb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_valid_reg <= '0;
            gather_reg    <= '0;
            phase_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            pad_reg       <= '0;
            finished_reg  <= 1'b0;
            in_byte_reg   <= 1'b0;
            shift_reg     <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pal_valid_reg <= pal_valid_next;
            gather_reg    <= gather_next;
            phase_reg     <= phase_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pad_reg       <= pad_next;
            finished_reg  <= finished_next;
            in_byte_reg   <= in_byte_next;
            shift_reg     <= shift_next;
            if (emit)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_adv)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            p1_reg <= p1_next;
        end
        if (p1_adv)
        begin
            out_reg.red          <= p1_rgb[23:16];
            out_reg.green        <= p1_rgb[15:8];
            out_reg.blue         <= p1_rgb[7:0];
            out_reg.alpha        <= p1_reg.alpha;
            out_reg.column       <= p1_reg.column;
            out_reg.row          <= p1_reg.row;
            out_reg.last_of_byte <= p1_reg.last;
            out_reg.image_done   <= p1_reg.done;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = out_reg;

    `ASSERT_CLK(a_done_is_last, p1_valid_reg && p1_reg.done |-> p1_reg.last, "done not last")
    `ASSERT_CLK(a_mid_byte_head, in_byte_reg |-> head.valid && head.req.op == OP_DATA, "lost byte")
    `ASSERT_CLK(a_p1_hold, p1_valid_reg && !out_adv |=> p1_valid_reg && $stable(p1_reg), "p1 moved")

endmodule

`default_nettype wire

### hdl/bmp_pixel_array_to_rgba_unit.sv
// ----------------------------------------------------------------------------
// bmp_pixel_array_to_rgba_unit
// bmp pixel-array bytes in, rgba8888 pixels with column and flipped row out
// ----------------------------------------------------------------------------
// Requests (start image, palette write, pixel byte) enter a queue of
// QUEUE_DEPTH entries and are taken by a sequencer that emits at most one pixel
// per clock unless the output stalls: a 1bpp byte holds it for up to eight
// pixels, a 4bpp byte for up to two, and the next byte waits until the last is
// through; unstalled input is one request per cycle in 8bpp or true-color mode.
// The rate is set by the single palette ram read port, one lookup per cycle; a
// pixel passes from the queue through the p1 stage to the output register. The
// palette reads as zero until each entry is written. The user writes the
// configuration over the apb port while the unit is idle; nothing enforces it.
`default_nettype none

module bmp_pixel_array_to_rgba_unit
    import bpa_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  palette_index,
    input  wire logic [7:0]  palette_red,
    input  wire logic [7:0]  palette_green,
    input  wire logic [7:0]  palette_blue,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [7:0]  red,
    output logic      [7:0]  green,
    output logic      [7:0]  blue,
    output logic      [7:0]  alpha,
    output logic      [11:0] column,
    output logic      [11:0] row,
    output logic             last_of_byte,
    output logic             image_done
);

    localparam logic [1:0] REG_PIXEL_FORMAT  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_ROW_PAD_BYTES = 2'd3;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        wr_en;
    queue_head_t head;
    logic        pop;
    pixel_t      pixel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_PIXEL_FORMAT:  cfg_next.pixel_format  = pwdata[2:0];
                REG_IMAGE_WIDTH:   cfg_next.image_width   = pwdata[12:0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = pwdata[12:0];
                REG_ROW_PAD_BYTES: cfg_next.row_pad_bytes = pwdata[1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PIXEL_FORMAT:  prdata = {29'd0, cfg_reg.pixel_format};
            REG_IMAGE_WIDTH:   prdata = {19'd0, cfg_reg.image_width};
            REG_IMAGE_HEIGHT:  prdata = {19'd0, cfg_reg.image_height};
            REG_ROW_PAD_BYTES: prdata = {30'd0, cfg_reg.row_pad_bytes};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_format  <= FMT_8BPP;
            cfg_reg.image_width   <= 13'd1;
            cfg_reg.image_height  <= 13'd1;
            cfg_reg.row_pad_bytes <= 2'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bpa_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .palette_index (palette_index),
        .palette_red   (palette_red),
        .palette_green (palette_green),
        .palette_blue  (palette_blue),
        .data_byte     (data_byte),
        .head          (head),
        .pop           (pop)
    );

    bpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel     (pixel)
    );

    assign red          = pixel.red;
    assign green        = pixel.green;
    assign blue         = pixel.blue;
    assign alpha        = pixel.alpha;
    assign column       = pixel.column;
    assign row          = pixel.row;
    assign last_of_byte = pixel.last_of_byte;
    assign image_done   = pixel.image_done;

endmodule

`default_nettype wire
